>>> hdl/icmppt_pkg.sv
package icmppt_pkg;

    // Field and register widths
    localparam int MEAS_W         = 16;
    localparam int TOL_W          = 16;
    localparam int BITS_W         = 5;
    localparam int VAL_W          = 16;
    localparam int DUTY_W         = 18;
    localparam int DUTY_BITS_MAX  = 16;

    // Shared multiplier and conductance datapath widths
    localparam int MUL_W  = ((MEAS_W > TOL_W) ? MEAS_W : TOL_W) + 2;
    localparam int PROD_W = 2 * MUL_W;
    localparam int NUM_W  = 2 * MEAS_W + 2;
    localparam int B_W    = 2 * MEAS_W;
    localparam int GB_W   = 2 * MEAS_W + TOL_W;
    localparam int LHS_W  = NUM_W + 10;
    localparam int CMP_W  = (GB_W > LHS_W) ? GB_W : LHS_W;

    // Register file
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [BITS_W-1:0] DUTY_BITS_RST = BITS_W'(10);
    localparam logic [TOL_W-1:0]  DV_TOL_RST    = TOL_W'(100);
    localparam logic [TOL_W-1:0]  DI_TOL_RST    = TOL_W'(5);
    localparam logic [TOL_W-1:0]  G_TOL_RST     = TOL_W'(100);

    typedef enum logic [1:0] {
        REG_DUTY_BITS = 2'd0,
        REG_DV_TOL    = 2'd1,
        REG_DI_TOL    = 2'd2,
        REG_G_TOL     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic              permission;
        logic [MEAS_W-1:0] voltage_mv;
        logic [MEAS_W-1:0] current_ma;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       next_task;
        logic             tracking_done;
        logic             duty_write;
        logic [VAL_W-1:0] duty_value;
    } t_out_item;

    typedef struct packed {
        logic [BITS_W-1:0] duty_bits;
        logic [TOL_W-1:0]  dv_tol_mv;
        logic [TOL_W-1:0]  di_tol_ma;
        logic [TOL_W-1:0]  g_tol_ms;
    } t_cfg;

    typedef enum logic [1:0] {
        TASK_SEND  = 2'd0,
        TASK_TRACK = 2'd1,
        TASK_MEAS  = 2'd2
    } t_task;

    typedef enum logic [1:0] {
        STG_SETUP  = 2'd0,
        STG_APPLY  = 2'd1,
        STG_DECIDE = 2'd2
    } t_stage;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_MUL1,
        CS_MUL2,
        CS_MUL3,
        CS_MUL4,
        CS_MUL5,
        CS_MUL6,
        CS_DONE
    } t_ctl_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DI_V,
        OP_I_DV,
        OP_ABSDV_V,
        OP_G_BLO,
        OP_G_BHI,
        OP_GB_SUM
    } t_mul_op;

    typedef enum logic [1:0] {
        DUTY_HOLD,
        DUTY_INIT,
        DUTY_CLAMP,
        DUTY_STEP
    } t_duty_op;

    typedef enum logic [1:0] {
        PREV_HOLD,
        PREV_CLEAR,
        PREV_CAPTURE
    } t_prev_op;

    typedef struct packed {
        logic     load;
        t_mul_op  mul_op;
        t_duty_op duty_op;
        t_prev_op prev_op;
    } t_dp_cmd;

    typedef struct packed {
        logic [VAL_W-1:0] duty_clamped;
    } t_dp_status;

endpackage

>>> hdl/incremental_conductance_mppt.sv
// Incremental-conductance MPPT step engine.
// Input channel (i_in_valid / o_in_ready, payload i_in): one measurement
// transaction per control step, carrying the permission bit, panel voltage
// in mV and panel current in mA. Output channel (o_out_valid / i_out_ready,
// payload o_out): exactly one result transaction per input transaction:
// next task, done flag, and the PWM duty with its write strobe.
// The step sequence is SETUP (repeated until permitted), APPLY, DECIDE,
// then APPLY and DECIDE alternate. SETUP and APPLY items go from
// accepting straight to commit; a DECIDE item first runs five products
// through the single shared 18x18 multiplier (dI*V, I*dV, |dV|*V and
// the two halves of the tolerance product), then one add of the tolerance
// halves, then the commit. A new transaction is taken only once the last
// is committed. A finished result sits in an output register; the next
// transaction is accepted while it waits. If the receiver stalls, the
// following item is processed and then held in its commit state until
// the register frees. Reset (synchronous, active low) returns to SETUP
// with duty and previous sample cleared and loads the default tolerances.
// Configuration is to be written over the APB-style port (pready always
// high) only while the block is idle; the block does not enforce this.
module incremental_conductance_mppt (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  icmppt_pkg::t_in_item                 i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output icmppt_pkg::t_out_item                o_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [icmppt_pkg::PADDR_W-1:0]       paddr,
    input  logic [icmppt_pkg::PDATA_W-1:0]       pwdata,
    output logic [icmppt_pkg::PDATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int PADDR_W = icmppt_pkg::PADDR_W;
    localparam int PDATA_W = icmppt_pkg::PDATA_W;
    localparam int BITS_W  = icmppt_pkg::BITS_W;
    localparam int TOL_W   = icmppt_pkg::TOL_W;

    icmppt_pkg::t_cfg       r_cfg;
    icmppt_pkg::t_reg_idx   reg_idx;
    icmppt_pkg::t_dp_cmd    dp_cmd;
    icmppt_pkg::t_dp_status dp_status;
    logic                   cfg_wr;

    // Register index comes from the word address; the byte offset is ignored
    assign reg_idx = icmppt_pkg::t_reg_idx'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Hold the tuning registers; load on the access phase of a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_bits <= icmppt_pkg::DUTY_BITS_RST;
            r_cfg.dv_tol_mv <= icmppt_pkg::DV_TOL_RST;
            r_cfg.di_tol_ma <= icmppt_pkg::DI_TOL_RST;
            r_cfg.g_tol_ms  <= icmppt_pkg::G_TOL_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                icmppt_pkg::REG_DUTY_BITS: r_cfg.duty_bits <= pwdata[BITS_W-1:0];
                icmppt_pkg::REG_DV_TOL:    r_cfg.dv_tol_mv <= pwdata[TOL_W-1:0];
                icmppt_pkg::REG_DI_TOL:    r_cfg.di_tol_ma <= pwdata[TOL_W-1:0];
                icmppt_pkg::REG_G_TOL:     r_cfg.g_tol_ms  <= pwdata[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back the addressed register, zero extended
    always_comb begin
        unique case (reg_idx)
            icmppt_pkg::REG_DUTY_BITS: prdata = PDATA_W'(r_cfg.duty_bits);
            icmppt_pkg::REG_DV_TOL:    prdata = PDATA_W'(r_cfg.dv_tol_mv);
            icmppt_pkg::REG_DI_TOL:    prdata = PDATA_W'(r_cfg.di_tol_ma);
            icmppt_pkg::REG_G_TOL:     prdata = PDATA_W'(r_cfg.g_tol_ms);
            default:                   prdata = '0;
        endcase
    end

    // Sequencer: owns the handshakes, the step stage and the result register
    icmppt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_permission (i_in.permission),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out),
        .o_cmd        (dp_cmd),
        .i_status     (dp_status)
    );

    // Datapath: sample deltas, shared multiplier, duty register and clamp
    icmppt_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_cfg    (r_cfg),
        .i_in     (i_in),
        .o_status (dp_status)
    );

endmodule

>>> hdl/icmppt_dp.sv
module icmppt_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  icmppt_pkg::t_dp_cmd    i_cmd,
    input  icmppt_pkg::t_cfg       i_cfg,
    input  icmppt_pkg::t_in_item   i_in,
    output icmppt_pkg::t_dp_status o_status
);

    localparam int MEAS_W = icmppt_pkg::MEAS_W;
    localparam int MUL_W  = icmppt_pkg::MUL_W;
    localparam int PROD_W = icmppt_pkg::PROD_W;
    localparam int NUM_W  = icmppt_pkg::NUM_W;
    localparam int B_W    = icmppt_pkg::B_W;
    localparam int CMP_W  = icmppt_pkg::CMP_W;
    localparam int DUTY_W = icmppt_pkg::DUTY_W;
    localparam int VAL_W  = icmppt_pkg::VAL_W;
    localparam int BITS_W = icmppt_pkg::BITS_W;

    logic [MEAS_W-1:0]        r_v, r_i, r_prev_v, r_prev_i;
    logic signed [MEAS_W:0]   r_dv, r_di;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [NUM_W-1:0]  r_num;
    logic [B_W-1:0]           r_b;
    logic [CMP_W-1:0]         r_lhs, r_gb;
    logic signed [DUTY_W-1:0] r_duty;

    logic [MEAS_W:0]          dv_mag, di_mag;
    logic [NUM_W-1:0]         num_mag;
    logic [CMP_W-1:0]         lhs_next;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     step_up, step_dn;
    logic [BITS_W-1:0]        eff_bits;
    logic [VAL_W:0]           dmax;
    logic [VAL_W-1:0]         dinit;
    logic signed [DUTY_W-1:0] d_clamp;

    assign dv_mag  = r_dv[MEAS_W] ? $unsigned(-r_dv) : $unsigned(r_dv);
    assign di_mag  = r_di[MEAS_W] ? $unsigned(-r_di) : $unsigned(r_di);
    assign num_mag = r_num[NUM_W-1] ? $unsigned(-r_num) : $unsigned(r_num);

    // 1000*x as 1024x - 32x + 8x
    assign lhs_next = (CMP_W'(num_mag) << 10) - (CMP_W'(num_mag) << 5)
                    + (CMP_W'(num_mag) << 3);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_op)
            icmppt_pkg::OP_DI_V: begin
                mul_a = MUL_W'(r_di);
                mul_b = $signed(MUL_W'(r_v));
            end
            icmppt_pkg::OP_I_DV: begin
                mul_a = $signed(MUL_W'(r_i));
                mul_b = MUL_W'(r_dv);
            end
            icmppt_pkg::OP_ABSDV_V: begin
                mul_a = $signed(MUL_W'(dv_mag));
                mul_b = $signed(MUL_W'(r_v));
            end
            icmppt_pkg::OP_G_BLO: begin
                mul_a = $signed(MUL_W'(i_cfg.g_tol_ms));
                mul_b = $signed(MUL_W'(r_prod[MEAS_W-1:0]));
            end
            icmppt_pkg::OP_G_BHI: begin
                mul_a = $signed(MUL_W'(i_cfg.g_tol_ms));
                mul_b = $signed(MUL_W'(r_b[B_W-1:MEAS_W]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Capture the sample and run the conductance products
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v  <= i_in.voltage_mv;
            r_i  <= i_in.current_ma;
            r_dv <= $signed({1'b0, i_in.voltage_mv}) - $signed({1'b0, r_prev_v});
            r_di <= $signed({1'b0, i_in.current_ma}) - $signed({1'b0, r_prev_i});
        end
        case (i_cmd.mul_op)
            icmppt_pkg::OP_DI_V: begin
                r_prod <= mul_p;
            end
            icmppt_pkg::OP_I_DV: begin
                r_num  <= NUM_W'(r_prod);
                r_prod <= mul_p;
            end
            icmppt_pkg::OP_ABSDV_V: begin
                r_num  <= r_num + NUM_W'(r_prod);
                r_prod <= mul_p;
            end
            icmppt_pkg::OP_G_BLO: begin
                r_b    <= r_prod[B_W-1:0];
                r_lhs  <= lhs_next;
                r_prod <= mul_p;
            end
            icmppt_pkg::OP_G_BHI: begin
                r_gb   <= CMP_W'($unsigned(r_prod));
                r_prod <= mul_p;
            end
            icmppt_pkg::OP_GB_SUM: begin
                r_gb <= r_gb + (CMP_W'($unsigned(r_prod)) << MEAS_W);
            end
            default: begin
            end
        endcase
    end

    // Step decision: small voltage change first, then conductance balance
    always_comb begin
        step_up = 1'b0;
        step_dn = 1'b0;
        if (dv_mag < i_cfg.dv_tol_mv) begin
            if (!(di_mag < i_cfg.di_tol_ma)) begin
                if (!r_di[MEAS_W] && (r_di != '0)) begin
                    step_up = 1'b1;
                end else begin
                    step_dn = 1'b1;
                end
            end
        end else if (r_v != '0) begin
            if (!(r_lhs < r_gb)) begin
                if ((!r_num[NUM_W-1] && (r_num != '0) && !r_dv[MEAS_W] && (r_dv != '0))
                    || (r_num[NUM_W-1] && r_dv[MEAS_W])) begin
                    step_up = 1'b1;
                end else begin
                    step_dn = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (i_cfg.duty_bits == '0) begin
            eff_bits = BITS_W'(1);
        end else if (i_cfg.duty_bits > BITS_W'(icmppt_pkg::DUTY_BITS_MAX)) begin
            eff_bits = BITS_W'(icmppt_pkg::DUTY_BITS_MAX);
        end else begin
            eff_bits = i_cfg.duty_bits;
        end
    end

    assign dmax  = ((VAL_W+1)'(1) << eff_bits) - (VAL_W+1)'(1);
    assign dinit = VAL_W'(1) << (eff_bits - BITS_W'(1));

    always_comb begin
        if (r_duty >= $signed(DUTY_W'(dmax))) begin
            d_clamp = $signed(DUTY_W'(dmax));
        end else if (r_duty <= $signed(DUTY_W'(1))) begin
            d_clamp = $signed(DUTY_W'(1));
        end else begin
            d_clamp = r_duty;
        end
    end

    assign o_status.duty_clamped = VAL_W'($unsigned(d_clamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty   <= '0;
            r_prev_v <= '0;
            r_prev_i <= '0;
        end else begin
            case (i_cmd.duty_op)
                icmppt_pkg::DUTY_INIT:  r_duty <= $signed(DUTY_W'(dinit));
                icmppt_pkg::DUTY_CLAMP: r_duty <= d_clamp;
                icmppt_pkg::DUTY_STEP: begin
                    if (step_up) begin
                        r_duty <= r_duty + $signed(DUTY_W'(1));
                    end else if (step_dn) begin
                        r_duty <= r_duty - $signed(DUTY_W'(1));
                    end
                end
                default: begin
                end
            endcase
            case (i_cmd.prev_op)
                icmppt_pkg::PREV_CLEAR: begin
                    r_prev_v <= '0;
                    r_prev_i <= '0;
                end
                icmppt_pkg::PREV_CAPTURE: begin
                    r_prev_v <= r_v;
                    r_prev_i <= r_i;
                end
                default: begin
                end
            endcase
        end
    end

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_duty >= $signed(DUTY_W'(0))) && (r_duty <= $signed(DUTY_W'(1 << VAL_W))))
        else $error("duty register left its range");

endmodule

>>> hdl/icmppt_ctrl.sv
module icmppt_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_permission,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output icmppt_pkg::t_out_item  o_out,
    output icmppt_pkg::t_dp_cmd    o_cmd,
    input  icmppt_pkg::t_dp_status i_status
);

    icmppt_pkg::t_ctl_state r_state, n_state;
    icmppt_pkg::t_stage     r_stage, n_stage;
    logic                   r_permit, n_permit;
    logic                   r_out_valid, n_out_valid;
    icmppt_pkg::t_out_item  r_out, n_out;
    logic                   in_fire, slot_free, out_load;

    assign o_in_ready  = (r_state == icmppt_pkg::CS_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= icmppt_pkg::CS_IDLE;
            r_stage     <= icmppt_pkg::STG_SETUP;
            r_permit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stage     <= n_stage;
            r_permit    <= n_permit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_stage       = r_stage;
        n_permit      = r_permit;
        n_out         = '0;
        out_load      = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.mul_op  = icmppt_pkg::OP_NONE;
        o_cmd.duty_op = icmppt_pkg::DUTY_HOLD;
        o_cmd.prev_op = icmppt_pkg::PREV_HOLD;
        unique case (r_state)
            icmppt_pkg::CS_IDLE: begin
                if (in_fire) begin
                    o_cmd.load = 1'b1;
                    n_permit   = i_permission;
                    n_state    = (r_stage == icmppt_pkg::STG_DECIDE) ?
                                 icmppt_pkg::CS_MUL1 : icmppt_pkg::CS_DONE;
                end
            end
            icmppt_pkg::CS_MUL1: begin
                o_cmd.mul_op = icmppt_pkg::OP_DI_V;
                n_state      = icmppt_pkg::CS_MUL2;
            end
            icmppt_pkg::CS_MUL2: begin
                o_cmd.mul_op = icmppt_pkg::OP_I_DV;
                n_state      = icmppt_pkg::CS_MUL3;
            end
            icmppt_pkg::CS_MUL3: begin
                o_cmd.mul_op = icmppt_pkg::OP_ABSDV_V;
                n_state      = icmppt_pkg::CS_MUL4;
            end
            icmppt_pkg::CS_MUL4: begin
                o_cmd.mul_op = icmppt_pkg::OP_G_BLO;
                n_state      = icmppt_pkg::CS_MUL5;
            end
            icmppt_pkg::CS_MUL5: begin
                o_cmd.mul_op = icmppt_pkg::OP_G_BHI;
                n_state      = icmppt_pkg::CS_MUL6;
            end
            icmppt_pkg::CS_MUL6: begin
                o_cmd.mul_op = icmppt_pkg::OP_GB_SUM;
                n_state      = icmppt_pkg::CS_DONE;
            end
            icmppt_pkg::CS_DONE: begin
                // Commit state and result together once the output slot is free
                if (slot_free) begin
                    out_load = 1'b1;
                    n_state  = icmppt_pkg::CS_IDLE;
                    case (r_stage)
                        icmppt_pkg::STG_SETUP: begin
                            if (!r_permit) begin
                                n_out.next_task     = icmppt_pkg::TASK_SEND;
                                n_out.tracking_done = 1'b1;
                            end else begin
                                o_cmd.prev_op   = icmppt_pkg::PREV_CLEAR;
                                o_cmd.duty_op   = icmppt_pkg::DUTY_INIT;
                                n_stage         = icmppt_pkg::STG_APPLY;
                                n_out.next_task = icmppt_pkg::TASK_TRACK;
                            end
                        end
                        icmppt_pkg::STG_APPLY: begin
                            o_cmd.duty_op    = icmppt_pkg::DUTY_CLAMP;
                            n_stage          = icmppt_pkg::STG_DECIDE;
                            n_out.next_task  = icmppt_pkg::TASK_MEAS;
                            n_out.duty_write = 1'b1;
                            n_out.duty_value = i_status.duty_clamped;
                        end
                        icmppt_pkg::STG_DECIDE: begin
                            o_cmd.duty_op   = icmppt_pkg::DUTY_STEP;
                            o_cmd.prev_op   = icmppt_pkg::PREV_CAPTURE;
                            n_stage         = icmppt_pkg::STG_APPLY;
                            n_out.next_task = icmppt_pkg::TASK_SEND;
                        end
                        default: begin
                            n_stage = icmppt_pkg::STG_SETUP;
                        end
                    endcase
                end
            end
            default: begin
                n_state = icmppt_pkg::CS_IDLE;
            end
        endcase
    end

    assign n_out_valid = out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == icmppt_pkg::CS_DONE))
        else $error("result appeared outside the commit state");

    a_write_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.duty_write) |-> (r_out.next_task == icmppt_pkg::TASK_MEAS))
        else $error("duty write without measurement task");

    a_done_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.tracking_done) |-> (r_stage == icmppt_pkg::STG_SETUP))
        else $error("done reported outside setup");

    a_write_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.duty_write) |-> (r_out.duty_value != '0))
        else $error("clamped duty is zero");

endmodule

>>> bench/tb_incremental_conductance_mppt.sv
`timescale 1ns / 100ps

module tb_incremental_conductance_mppt;

    localparam int CLK_NS          = 10;
    localparam int RST_CYCLES      = 12;
    localparam int SETTLE_CYCLES   = 16;
    localparam int MAX_SHOWN       = 10;
    localparam int DIRECTED_N      = 22;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int WATCHDOG_NS     = 5_000_000;
    localparam int PADDR_W         = icmppt_pkg::PADDR_W;
    localparam int PDATA_W         = icmppt_pkg::PDATA_W;
    localparam int BITS_W          = icmppt_pkg::BITS_W;
    localparam int TOL_W           = icmppt_pkg::TOL_W;

    // One row of the directed table: the measurement, and where the answer is
    // obvious, the result typed in by hand.
    typedef struct {
        icmppt_pkg::t_in_item  item;
        bit                    typed;
        icmppt_pkg::t_out_item want;
    } t_step_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    icmppt_pkg::t_in_item  i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    icmppt_pkg::t_out_item o_out;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // Tracker state mirrored for prediction
    icmppt_pkg::t_cfg   cfg_now;
    icmppt_pkg::t_stage trk_stage;
    logic [15:0]        prev_v;
    logic [15:0]        prev_i;
    int                 duty_level;

    icmppt_pkg::t_out_item pending_results[$];
    int          mismatches;
    int          results_checked;
    int          items_sent;
    int          send_idle_pct;
    int          stall_pct;

    // Directed sequence, run with reset register values. Rows alternate
    // APPLY / DECIDE once the first permitted SETUP has passed.
    t_step_row directed_steps [DIRECTED_N] = '{
        // SETUP without permission: report done, stay put
        '{'{1'b0, 16'hFFFF, 16'hFFFF}, 1'b1, '{icmppt_pkg::TASK_SEND, 1'b1, 1'b0, 16'd0}},
        '{'{1'b0, 16'h0000, 16'h0000}, 1'b1, '{icmppt_pkg::TASK_SEND, 1'b1, 1'b0, 16'd0}},
        // SETUP with permission: duty starts at half of 2^10
        '{'{1'b1, 16'h1234, 16'h5678}, 1'b1, '{icmppt_pkg::TASK_TRACK, 1'b0, 1'b0, 16'd0}},
        // first APPLY, permission bit ignored from here on
        '{'{1'b0, 16'hFFFF, 16'h0000}, 1'b1, '{icmppt_pkg::TASK_MEAS, 1'b0, 1'b1, 16'd512}},
        '{'{1'b1, 16'd50,   16'd3},    1'b0, '0},   // small dV, small dI: hold
        '{'{1'b1, 16'h0000, 16'hFFFF}, 1'b0, '0},
        '{'{1'b0, 16'd60,   16'd20},   1'b0, '0},   // small dV, rising current
        '{'{1'b0, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{1'b1, 16'd90,   16'd0},    1'b0, '0},   // small dV, falling current
        '{'{1'b1, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{1'b1, 16'd300,  16'd12},   1'b0, '0},   // conductances just balance
        '{'{1'b0, 16'hAAAA, 16'h5555}, 1'b0, '0},
        '{'{1'b1, 16'hFFFF, 16'hFFFF}, 1'b0, '0},   // both at full scale
        '{'{1'b1, 16'h5555, 16'hAAAA}, 1'b0, '0},
        '{'{1'b0, 16'h0000, 16'hFFFF}, 1'b0, '0},   // zero voltage holds
        '{'{1'b0, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{1'b1, 16'hFFFF, 16'h0000}, 1'b0, '0},   // big dV up, current collapses
        '{'{1'b1, 16'h8000, 16'h8000}, 1'b0, '0},
        '{'{1'b0, 16'h8000, 16'h8000}, 1'b0, '0},
        '{'{1'b1, 16'h0001, 16'h0001}, 1'b0, '0},
        '{'{1'b1, 16'h8000, 16'h8000}, 1'b0, '0},   // no change at all
        '{'{1'b0, 16'h7FFF, 16'h7FFF}, 1'b0, '0}
    };

    // Register settings per phase: reset values, low and high extremes,
    // out-of-range resolutions, then a spread of ordinary ones.
    icmppt_pkg::t_cfg phase_cfg [NUM_PHASES] = '{
        '{5'd10, 16'd100,   16'd5,     16'd100},
        '{5'd1,  16'd0,     16'd0,     16'd0},
        '{5'd16, 16'hFFFF,  16'hFFFF,  16'hFFFF},
        '{5'd0,  16'd50,    16'd3,     16'd10},
        '{5'd31, 16'd200,   16'd20,    16'd1000},
        '{5'd4,  16'd30,    16'd2,     16'd500},
        '{5'd12, 16'd1000,  16'd100,   16'hFFFF},
        '{5'd2,  16'd100,   16'd5,     16'd100}
    };

    // Pacing modes: none, sender gaps, receiver stalls, both
    int sender_gap_pct   [4] = '{0, 52, 0, 17};
    int receiver_hold_pct[4] = '{0, 0, 52, 17};

    incremental_conductance_mppt uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_NS / 2) i_clk = ~i_clk;
    end

    // Log a failure; print only the first few in detail.
    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endfunction

    function automatic logic [15:0] fit16(longint x);
        return (x < 0) ? 16'd0 : ((x > 65535) ? 16'hFFFF : 16'(x));
    endfunction

    function automatic int eff_duty_bits();
        if (cfg_now.duty_bits < 1) return 1;
        if (cfg_now.duty_bits > icmppt_pkg::DUTY_BITS_MAX) return icmppt_pkg::DUTY_BITS_MAX;
        return int'(cfg_now.duty_bits);
    endfunction

    // Duty step of one DECIDE: +1, 0 (hold) or -1.
    function automatic int conductance_step(logic [15:0] v, logic [15:0] i);
        longint dv;
        longint di;
        longint dv_mag;
        longint di_mag;
        longint num;
        longint num_mag;
        dv     = longint'(v) - longint'(prev_v);
        di     = longint'(i) - longint'(prev_i);
        dv_mag = (dv < 0) ? -dv : dv;
        di_mag = (di < 0) ? -di : di;
        // Voltage barely moved: follow the current alone
        if (dv_mag < longint'(cfg_now.dv_tol_mv)) begin
            if (di_mag < longint'(cfg_now.di_tol_ma)) return 0;
            return (di > 0) ? 1 : -1;
        end
        if (v == 16'd0) return 0;
        // |dI/dV + I/V| < g/1000, cross-multiplied to stay in integers
        num     = di * longint'(v) + longint'(i) * dv;
        num_mag = (num < 0) ? -num : num;
        if (num_mag * 1000 < longint'(cfg_now.g_tol_ms) * dv_mag * longint'(v)) return 0;
        if ((num > 0 && dv > 0) || (num < 0 && dv < 0)) return 1;
        return -1;
    endfunction

    // Advance the mirrored tracker by one measurement and return its result.
    function automatic icmppt_pkg::t_out_item track_step(icmppt_pkg::t_in_item it);
        icmppt_pkg::t_out_item r;
        int                    dmax;
        r = '0;
        case (trk_stage)
            icmppt_pkg::STG_SETUP: begin
                if (!it.permission) begin
                    r.next_task     = icmppt_pkg::TASK_SEND;
                    r.tracking_done = 1'b1;
                end else begin
                    prev_v      = '0;
                    prev_i      = '0;
                    duty_level  = 1 << (eff_duty_bits() - 1);
                    trk_stage   = icmppt_pkg::STG_APPLY;
                    r.next_task = icmppt_pkg::TASK_TRACK;
                end
            end
            icmppt_pkg::STG_APPLY: begin
                dmax = (1 << eff_duty_bits()) - 1;
                if (duty_level >= dmax) duty_level = dmax;
                else if (duty_level <= 1) duty_level = 1;
                r.duty_write = 1'b1;
                r.duty_value = 16'(duty_level);
                r.next_task  = icmppt_pkg::TASK_MEAS;
                trk_stage    = icmppt_pkg::STG_DECIDE;
            end
            icmppt_pkg::STG_DECIDE: begin
                duty_level  = duty_level + conductance_step(it.voltage_mv, it.current_ma);
                prev_v      = it.voltage_mv;
                prev_i      = it.current_ma;
                r.next_task = icmppt_pkg::TASK_SEND;
                trk_stage   = icmppt_pkg::STG_APPLY;
            end
            default: begin
                trk_stage = icmppt_pkg::STG_SETUP;
            end
        endcase
        return r;
    endfunction

    // Random measurement, biased toward the interesting decision regions
    // around the last sample the tracker kept.
    function automatic icmppt_pkg::t_in_item pick_stimulus();
        icmppt_pkg::t_in_item it;
        int                   kind;
        int                   span;
        longint               v;
        longint               den;
        it.permission = 1'($urandom_range(1));
        kind = int'($urandom_range(99));
        if (kind < 30) begin
            // hug the previous sample, straddling both tolerance windows
            span = 2 * int'(cfg_now.dv_tol_mv) + 4;
            it.voltage_mv = fit16(longint'(prev_v) + int'($urandom_range(2 * span)) - span);
            span = 2 * int'(cfg_now.di_tol_ma) + 4;
            it.current_ma = fit16(longint'(prev_i) + int'($urandom_range(2 * span)) - span);
        end else if (kind < 60) begin
            // solve dI*V + I*dV ~ 0 for I, then jitter around the balance
            v   = longint'($urandom_range(65535, 1));
            den = 2 * v - longint'(prev_v);
            it.voltage_mv = 16'(v);
            if (den > 0) begin
                it.current_ma = fit16(longint'(prev_i) * v / den + int'($urandom_range(6)) - 3);
            end else begin
                it.current_ma = 16'($urandom);
            end
        end else if (kind < 68) begin
            it.voltage_mv = 16'd0;
            it.current_ma = 16'($urandom);
        end else if (kind < 80) begin
            it.voltage_mv = {16{1'($urandom_range(1))}};
            it.current_ma = {16{1'($urandom_range(1))}};
        end else begin
            it.voltage_mv = 16'($urandom);
            it.current_ma = 16'($urandom);
        end
        return it;
    endfunction

    // Present one measurement transaction, hold it until accepted, then
    // record what should come back.
    task automatic send_item(input icmppt_pkg::t_in_item it, input bit typed,
                             input icmppt_pkg::t_out_item want);
        icmppt_pkg::t_out_item predicted;
        while (int'($urandom_range(99)) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = track_step(it);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Drop valid and let every outstanding result drain, plus settle time.
    task automatic wait_for_quiet();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write followed by a read back of the same register.
    task automatic write_reg(input icmppt_pkg::t_reg_idx idx,
                             input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            icmppt_pkg::REG_DUTY_BITS: cfg_now.duty_bits = value[BITS_W-1:0];
            icmppt_pkg::REG_DV_TOL:    cfg_now.dv_tol_mv = value[TOL_W-1:0];
            icmppt_pkg::REG_DI_TOL:    cfg_now.di_tol_ma = value[TOL_W-1:0];
            icmppt_pkg::REG_G_TOL:     cfg_now.g_tol_ms  = value[TOL_W-1:0];
            default:                   ;
        endcase
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== value) begin
            note_mismatch($sformatf("register %s read back %h, wrote %h",
                                    idx.name(), readback, value));
        end
    endtask

    // Receiver: accept or stall each cycle according to the current mode.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_ready <= (int'($urandom_range(99)) >= stall_pct);
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result %h with nothing outstanding", o_out));
            end else begin
                automatic icmppt_pkg::t_out_item want = pending_results.pop_front();
                if (o_out.next_task !== want.next_task
                        || o_out.tracking_done !== want.tracking_done
                        || o_out.duty_write !== want.duty_write
                        || o_out.duty_value !== want.duty_value) begin
                    note_mismatch($sformatf(
                        "result %0d: want task %0d done %0b wr %0b duty %0d, got %0d %0b %0b %0d",
                        results_checked, want.next_task, want.tracking_done,
                        want.duty_write, want.duty_value, o_out.next_task,
                        o_out.tracking_done, o_out.duty_write, o_out.duty_value));
                end
                results_checked++;
            end
        end
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(WATCHDOG_NS);
        $display("Run stalled with %0d results outstanding", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        mismatches      = 0;
        results_checked = 0;
        items_sent      = 0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        cfg_now    = '{icmppt_pkg::DUTY_BITS_RST, icmppt_pkg::DV_TOL_RST,
                       icmppt_pkg::DI_TOL_RST, icmppt_pkg::G_TOL_RST};
        trk_stage  = icmppt_pkg::STG_SETUP;
        prev_v     = '0;
        prev_i     = '0;
        duty_level = 0;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk with reset register values, no pacing
        for (int k = 0; k < DIRECTED_N; k++) begin
            send_item(directed_steps[k].item, directed_steps[k].typed, directed_steps[k].want);
        end

        // Random phases: reprogram while idle, then stream measurements
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_for_quiet();
            send_idle_pct = sender_gap_pct[p % 4];
            stall_pct     = receiver_hold_pct[p % 4];
            write_reg(icmppt_pkg::REG_DUTY_BITS, PDATA_W'(phase_cfg[p].duty_bits));
            write_reg(icmppt_pkg::REG_DV_TOL,    PDATA_W'(phase_cfg[p].dv_tol_mv));
            write_reg(icmppt_pkg::REG_DI_TOL,    PDATA_W'(phase_cfg[p].di_tol_ma));
            write_reg(icmppt_pkg::REG_G_TOL,     PDATA_W'(phase_cfg[p].g_tol_ms));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // in phase 2 only, hold off mid-phase until the pipeline is empty
                if (p == 2 && n == ITEMS_PER_PHASE / 2) begin
                    wait_for_quiet();
                end
                send_item(pick_stimulus(), 1'b0, '0);
            end
        end

        wait_for_quiet();
        $display("Covered %0d measurement transactions over %0d register settings",
                 items_sent, NUM_PHASES);
        $display("and four pacing modes; %0d results compared, %0d failures",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
